// ----- src/fsp_pkg.sv -----
package fsp_pkg;

    // Width of the width and precision accumulators; values saturate at all ones
    localparam int NUMBER_BITS = 16;

    // Width of the width and precision fields on the result channel
    localparam int FIELD_BITS = 16;

    typedef logic [NUMBER_BITS-1:0] acc_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_FLAGS = 3'd1,
        ST_WIDTH = 3'd2,
        ST_PREC  = 3'd3,
        ST_LEN   = 3'd4,
        ST_LEN2  = 3'd5,
        ST_CONV  = 3'd6
    } stage_t;

    // Length modifier codes; q is held internally and reported as ll
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_H     = 3'd1;
    localparam logic [2:0] LEN_L     = 3'd2;
    localparam logic [2:0] LEN_BIG_L = 3'd3;
    localparam logic [2:0] LEN_J     = 3'd4;
    localparam logic [2:0] LEN_Z     = 3'd5;
    localparam logic [2:0] LEN_T     = 3'd6;
    localparam logic [2:0] LEN_Q_RAW = 3'd7;

    localparam logic [1:0] LEN2_NONE = 2'd0;
    localparam logic [1:0] LEN2_H    = 2'd1;
    localparam logic [1:0] LEN2_L    = 2'd2;

    // Classification of one character
    typedef struct packed {
        logic       is_flag;
        logic [5:0] flag_mask;
        logic       is_digit;
        logic [3:0] digit_val;
        logic       is_dot;
        logic [2:0] len_code;
        logic       is_len2;
        logic [1:0] len2_code;
        logic       is_conv;
    } char_class_t;

    // One parsed specification
    typedef struct packed {
        logic [5:0]            flag_bits;
        logic [FIELD_BITS-1:0] field_width;
        logic                  precision_given;
        logic [FIELD_BITS-1:0] precision_value;
        logic [2:0]            length_first;
        logic [1:0]            length_second;
        logic                  conversion_found;
        logic [7:0]            conversion_char;
        logic                  last_char_used;
    } spec_t;

    // Multiply by ten and add a digit, saturating at all ones
    function automatic acc_t acc_step(acc_t acc, logic [3:0] digit);
        logic [NUMBER_BITS+3:0] ext;
        logic [NUMBER_BITS+3:0] sum;
        ext = (NUMBER_BITS + 4)'(acc);
        sum = (ext << 3) + (ext << 1) + (NUMBER_BITS + 4)'(digit);
        if (sum[NUMBER_BITS+3:NUMBER_BITS] != 4'd0)
        begin
            return '1;
        end
        return sum[NUMBER_BITS-1:0];
    endfunction

    // Fit an accumulator onto a result field
    function automatic logic [FIELD_BITS-1:0] to_field(acc_t acc);
        logic [31:0] wide;
        wide = 32'(acc);
        return wide[FIELD_BITS-1:0];
    endfunction

endpackage

// ----- src/fsp_char_if.sv -----
interface fsp_char_if;
    import fsp_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

// ----- src/fsp_spec_if.sv -----
interface fsp_spec_if;
    import fsp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [5:0]            flag_bits;
    logic [FIELD_BITS-1:0] field_width;
    logic                  precision_given;
    logic [FIELD_BITS-1:0] precision_value;
    logic [2:0]            length_first;
    logic [1:0]            length_second;
    logic                  conversion_found;
    logic [7:0]            conversion_char;
    logic                  last_char_used;

    modport source (
        output valid, output flag_bits, output field_width, output precision_given,
        output precision_value, output length_first, output length_second,
        output conversion_found, output conversion_char, output last_char_used,
        input ready
    );
    modport sink (
        input valid, input flag_bits, input field_width, input precision_given,
        input precision_value, input length_first, input length_second,
        input conversion_found, input conversion_char, input last_char_used,
        output ready
    );
endinterface

// ----- src/fsp_classify.sv -----
module fsp_classify
    import fsp_pkg::*;
(
    input  logic [7:0]  char_in,
    output char_class_t char_class
);

    // Sort the character into the sets each stage looks for
    always_comb
    begin
        char_class = '0;
        char_class.is_digit  = (char_in >= 8'h30) && (char_in <= 8'h39);
        char_class.digit_val = char_in[3:0];
        char_class.is_dot    = (char_in == 8'h2E);

        unique case (char_in)
            8'h23:   char_class.flag_mask = 6'b000001; // '#'
            8'h30:   char_class.flag_mask = 6'b000010; // '0'
            8'h2D:   char_class.flag_mask = 6'b000100; // '-'
            8'h20:   char_class.flag_mask = 6'b001000; // ' '
            8'h2B:   char_class.flag_mask = 6'b010000; // '+'
            8'h27:   char_class.flag_mask = 6'b100000; // quote
            default: char_class.flag_mask = 6'b000000;
        endcase
        char_class.is_flag = (char_class.flag_mask != 6'b000000);

        unique case (char_in)
            8'h68:   char_class.len_code = LEN_H;     // h
            8'h6C:   char_class.len_code = LEN_L;     // l
            8'h4C:   char_class.len_code = LEN_BIG_L; // L
            8'h6A:   char_class.len_code = LEN_J;     // j
            8'h7A:   char_class.len_code = LEN_Z;     // z
            8'h5A:   char_class.len_code = LEN_Z;     // Z maps to z
            8'h74:   char_class.len_code = LEN_T;     // t
            8'h71:   char_class.len_code = LEN_Q_RAW; // q
            default: char_class.len_code = LEN_NONE;
        endcase

        unique case (char_in)
            8'h68:   char_class.len2_code = LEN2_H;
            8'h6C:   char_class.len2_code = LEN2_L;
            default: char_class.len2_code = LEN2_NONE;
        endcase
        char_class.is_len2 = (char_class.len2_code != LEN2_NONE);

        // diouxXeEfFgGaAcsCSPnm%
        unique case (char_in)
            8'h64, 8'h69, 8'h6F, 8'h75, 8'h78, 8'h58,
            8'h65, 8'h45, 8'h66, 8'h46, 8'h67, 8'h47,
            8'h61, 8'h41, 8'h63, 8'h73, 8'h43, 8'h53,
            8'h50, 8'h6E, 8'h6D, 8'h25:
                char_class.is_conv = 1'b1;
            default:
                char_class.is_conv = 1'b0;
        endcase
    end

endmodule

// ----- src/fsp_spec_state.sv -----
module fsp_spec_state
    import fsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic [7:0]  char_in,
    input  char_class_t char_class,
    output logic        result_valid,
    output spec_t       result
);

    stage_t     stage_reg, stage_next;
    logic [5:0] flags_reg, flags_next;
    acc_t       width_reg, width_next;
    logic       dot_reg, dot_next;
    acc_t       prec_reg, prec_next;
    logic [2:0] len1_reg, len1_next;
    logic [1:0] len2_reg, len2_next;

    logic is_idle;
    logic try_width;
    logic try_len;
    logic take_flag;
    logic take_wdig;
    logic take_dot;
    logic take_pdig;
    logic take_len;
    logic take_len2;
    logic spec_end;

    // Decode which stages the character is offered to, falling through in order
    assign is_idle   = !((stage_reg == ST_FLAGS) || (stage_reg == ST_WIDTH) ||
                         (stage_reg == ST_PREC)  || (stage_reg == ST_LEN)   ||
                         (stage_reg == ST_LEN2)  || (stage_reg == ST_CONV));
    assign take_flag = (stage_reg == ST_FLAGS) && char_class.is_flag;
    assign try_width = ((stage_reg == ST_FLAGS) && !char_class.is_flag) ||
                       (stage_reg == ST_WIDTH);
    assign take_wdig = try_width && char_class.is_digit;
    assign take_dot  = try_width && char_class.is_dot;
    assign take_pdig = (stage_reg == ST_PREC) && char_class.is_digit;
    assign try_len   = (try_width && !char_class.is_digit && !char_class.is_dot) ||
                       ((stage_reg == ST_PREC) && !char_class.is_digit) ||
                       (stage_reg == ST_LEN);
    assign take_len  = try_len && (char_class.len_code != LEN_NONE);
    assign take_len2 = (stage_reg == ST_LEN2) && char_class.is_len2;
    assign spec_end  = !is_idle && !take_flag && !take_wdig && !take_dot &&
                       !take_pdig && !take_len && !take_len2;

    // Next stage
    always_comb
    begin
        priority if (is_idle)
            stage_next = ST_FLAGS;
        else if (take_flag)
            stage_next = ST_FLAGS;
        else if (take_wdig)
            stage_next = ST_WIDTH;
        else if (take_dot || take_pdig)
            stage_next = ST_PREC;
        else if (take_len)
            stage_next = ST_LEN2;
        else if (take_len2)
            stage_next = ST_CONV;
        else
            stage_next = ST_IDLE;
    end

    // Accumulate spec fields; drop them all once the spec ends
    always_comb
    begin
        flags_next = flags_reg;
        width_next = width_reg;
        dot_next   = dot_reg;
        prec_next  = prec_reg;
        len1_next  = len1_reg;
        len2_next  = len2_reg;
        if (spec_end)
        begin
            flags_next = '0;
            width_next = '0;
            dot_next   = 1'b0;
            prec_next  = '0;
            len1_next  = LEN_NONE;
            len2_next  = LEN2_NONE;
        end
        else
        begin
            if (take_flag)
                flags_next = flags_reg | char_class.flag_mask;
            if (take_wdig)
                width_next = acc_step(width_reg, char_class.digit_val);
            if (take_dot)
                dot_next = 1'b1;
            if (take_pdig)
                prec_next = acc_step(prec_reg, char_class.digit_val);
            if (take_len)
                len1_next = char_class.len_code;
            if (take_len2)
                len2_next = char_class.len2_code;
        end
    end

    // Form the result from the held fields and the ending character
    always_comb
    begin
        result_valid            = step_en && spec_end;
        result.flag_bits        = flags_reg;
        result.field_width      = to_field(width_reg);
        result.precision_given  = dot_reg;
        result.precision_value  = to_field(prec_reg);
        result.length_first     = len1_reg;
        result.length_second    = len2_reg;
        if (len1_reg == LEN_Q_RAW)
        begin
            result.length_first  = LEN_L;
            result.length_second = LEN2_L;
        end
        result.conversion_found = char_class.is_conv;
        result.conversion_char  = char_class.is_conv ? char_in : 8'd0;
        result.last_char_used   = char_class.is_conv;
    end

    // Advance the parse state on each processed character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_IDLE;
            flags_reg <= '0;
            width_reg <= '0;
            dot_reg   <= 1'b0;
            prec_reg  <= '0;
            len1_reg  <= LEN_NONE;
            len2_reg  <= LEN2_NONE;
        end
        else if (step_en)
        begin
            stage_reg <= stage_next;
            flags_reg <= flags_next;
            width_reg <= width_next;
            dot_reg   <= dot_next;
            prec_reg  <= prec_next;
            len1_reg  <= len1_next;
            len2_reg  <= len2_next;
        end
    end

endmodule

// ----- src/format_specifier_parser.sv -----
// Path: an accepted item is held in the input register and parsed by the combinational
// parse step; a result it completes is loaded into the result register and offered
// on spec_chan from there.
// Throughput: one character per cycle, set by the parse step between the input
// register and the result register; a stalled result stalls input.
// Reset: rst_n clears the parse state to idle and empties both registers.
module format_specifier_parser
    import fsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    fsp_char_if.sink          char_chan,
    fsp_spec_if.source        spec_chan
);

    logic [7:0]  char_reg;
    logic        char_valid_reg, char_valid_next;
    spec_t       res_reg;
    logic        res_valid_reg, res_valid_next;

    logic        step_en;
    char_class_t char_class;
    logic        step_result_valid;
    spec_t       step_result;

    // Process the held item whenever the result register has room
    assign step_en         = char_valid_reg && (!res_valid_reg || spec_chan.ready);
    assign char_chan.ready = !char_valid_reg || step_en;

    fsp_classify u_classify (
        .char_in    (char_reg),
        .char_class (char_class)
    );

    fsp_spec_state u_spec_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .char_in      (char_reg),
        .char_class   (char_class),
        .result_valid (step_result_valid),
        .result       (step_result)
    );

    // Hold the incoming item until it is processed
    assign char_valid_next = (char_chan.valid && char_chan.ready) ||
                             (char_valid_reg && !step_en);

    // Hold the result until it is taken
    assign res_valid_next = (res_valid_reg && !spec_chan.ready) || step_result_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            char_valid_reg <= char_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (char_chan.valid && char_chan.ready)
            char_reg <= char_chan.char_in;
        if (step_result_valid)
            res_reg <= step_result;
    end

    // Drive the result channel
    assign spec_chan.valid            = res_valid_reg;
    assign spec_chan.flag_bits        = res_reg.flag_bits;
    assign spec_chan.field_width      = res_reg.field_width;
    assign spec_chan.precision_given  = res_reg.precision_given;
    assign spec_chan.precision_value  = res_reg.precision_value;
    assign spec_chan.length_first     = res_reg.length_first;
    assign spec_chan.length_second    = res_reg.length_second;
    assign spec_chan.conversion_found = res_reg.conversion_found;
    assign spec_chan.conversion_char  = res_reg.conversion_char;
    assign spec_chan.last_char_used   = res_reg.last_char_used;

endmodule

// ----- sim/tb_format_specifier_parser.sv -----
module tb_format_specifier_parser;
    import fsp_pkg::*;

    localparam int    CYCLE_LIMIT  = 200000;
    localparam int    RANDOM_ITEMS = 700;
    localparam int    QUIET_ITEMS  = 100;
    localparam int    DIR_ROWS     = 26;
    localparam int    MAX_REPORTS  = 10;
    localparam string FLAG_SET     = "#0- +'";
    localparam string LEN_SET      = "hlLjzZtq";
    localparam string CONV_SET     = "diouxXeEfFgGaAcsCSPnm%";

    // Results that can be read straight off the spec
    localparam spec_t SPEC_EMPTY = '0;
    localparam spec_t SPEC_SATURATED = '{
        flag_bits: 6'h3f, field_width: 16'hffff, precision_given: 1'b1,
        precision_value: 16'hffff, length_first: LEN_L, length_second: LEN2_L,
        conversion_found: 1'b1, conversion_char: 8'h25, last_char_used: 1'b1
    };
    localparam spec_t SPEC_Z_ONLY = '{
        flag_bits: 6'h00, field_width: 16'h0000, precision_given: 1'b0,
        precision_value: 16'h0000, length_first: LEN_Z, length_second: LEN2_NONE,
        conversion_found: 1'b0, conversion_char: 8'h00, last_char_used: 1'b0
    };

    typedef struct {
        logic [7:0] ch;
        bit         typed;
        spec_t      want;
    } char_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fsp_char_if char_bus();
    fsp_spec_if spec_bus();

    format_specifier_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_chan (char_bus),
        .spec_chan (spec_bus)
    );

    always #10 clk = ~clk;

    // Parse state of the predictor
    stage_t     ps_stage;
    logic [5:0] ps_flags;
    acc_t       ps_width;
    logic       ps_dot;
    acc_t       ps_prec;
    logic [2:0] ps_len1;
    logic [1:0] ps_len2;

    spec_t      pending_specs[$];
    logic [7:0] spec_bytes[$];
    char_row_t  dir_table[DIR_ROWS];
    int         idle_pct = 0;
    int         chars_sent = 0;
    int         failures = 0;
    int         cycles = 0;

    function automatic void clear_parse();
        ps_stage = ST_IDLE;
        ps_flags = '0;
        ps_width = '0;
        ps_dot   = 1'b0;
        ps_prec  = '0;
        ps_len1  = LEN_NONE;
        ps_len2  = LEN2_NONE;
    endfunction

    // Times ten plus digit, held at all ones once it overflows
    function automatic acc_t sat_digit(acc_t acc, logic [7:0] c);
        longint unsigned nxt;
        longint unsigned maxv;
        maxv = (64'd1 << NUMBER_BITS) - 1;
        nxt  = 64'(acc) * 10 + 64'(c - 8'h30);
        return (nxt > maxv) ? '1 : acc_t'(nxt);
    endfunction

    function automatic logic [2:0] len_of(logic [7:0] c);
        case (c)
            "h":      return LEN_H;
            "l":      return LEN_L;
            "L":      return LEN_BIG_L;
            "j":      return LEN_J;
            "z", "Z": return LEN_Z;
            "t":      return LEN_T;
            "q":      return LEN_Q_RAW;
            default:  return LEN_NONE;
        endcase
    endfunction

    // Advance the parse by one character; return 1 when a spec is complete
    function automatic bit parse_char(logic [7:0] c, output spec_t res);
        stage_t     s;
        bit         dig;
        bit         found;
        logic [5:0] fmask;
        logic [2:0] code;
        res   = '0;
        s     = ps_stage;
        dig   = (c >= "0") && (c <= "9");
        found = 1'b0;
        fmask = '0;
        if (s == ST_IDLE)
        begin
            ps_stage = ST_FLAGS;
            return 1'b0;
        end
        if (s == ST_FLAGS)
        begin
            for (int i = 0; i < FLAG_SET.len(); i++)
                if (FLAG_SET[i] == c)
                    fmask[i] = 1'b1;
            if (fmask != '0)
            begin
                ps_flags |= fmask;
                return 1'b0;
            end
            s = ST_WIDTH;
        end
        if (s == ST_WIDTH)
        begin
            if (dig)
            begin
                ps_width = sat_digit(ps_width, c);
                ps_stage = ST_WIDTH;
                return 1'b0;
            end
            if (c == ".")
            begin
                ps_dot   = 1'b1;
                ps_stage = ST_PREC;
                return 1'b0;
            end
            s = ST_LEN;
        end
        if (s == ST_PREC)
        begin
            if (dig)
            begin
                ps_prec  = sat_digit(ps_prec, c);
                ps_stage = ST_PREC;
                return 1'b0;
            end
            s = ST_LEN;
        end
        if (s == ST_LEN)
        begin
            code = len_of(c);
            if (code != LEN_NONE)
            begin
                ps_len1  = code;
                ps_stage = ST_LEN2;
                return 1'b0;
            end
            s = ST_CONV;
        end
        if (s == ST_LEN2 && (c == "h" || c == "l"))
        begin
            ps_len2  = (c == "h") ? LEN2_H : LEN2_L;
            ps_stage = ST_CONV;
            return 1'b0;
        end

        // Close the spec on whatever byte got this far
        for (int i = 0; i < CONV_SET.len(); i++)
            if (c != 8'h00 && CONV_SET[i] == c)
                found = 1'b1;
        res.flag_bits        = ps_flags;
        res.field_width      = FIELD_BITS'(ps_width);
        res.precision_given  = ps_dot;
        res.precision_value  = FIELD_BITS'(ps_prec);
        res.length_first     = (ps_len1 == LEN_Q_RAW) ? LEN_L : ps_len1;
        res.length_second    = (ps_len1 == LEN_Q_RAW) ? LEN2_L : ps_len2;
        res.conversion_found = found;
        res.conversion_char  = found ? c : 8'h00;
        res.last_char_used   = found;
        clear_parse();
        return 1'b1;
    endfunction

    function automatic string spec_text(spec_t sp);
        return $sformatf("flags=%h width=%0d dot=%0b prec=%0d len=%0d/%0d conv=%0b/%h used=%0b",
            sp.flag_bits, sp.field_width, sp.precision_given, sp.precision_value,
            sp.length_first, sp.length_second, sp.conversion_found,
            sp.conversion_char, sp.last_char_used);
    endfunction

    // Offer one character, wait for acceptance, then predict its outcome
    task automatic send_char(logic [7:0] c, bit typed, spec_t want);
        spec_t got;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        char_bus.valid   <= 1'b1;
        char_bus.char_in <= c;
        do
            @(posedge clk);
        while (char_bus.ready !== 1'b1);
        if (parse_char(c, got))
            pending_specs.push_back(typed ? want : got);
        chars_sent++;
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    // Build one random spec: mostly well formed, some noise and broken tails
    task automatic build_spec();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        spec_bytes = {};
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 4)) spec_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        spec_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : "%");
        repeat ($urandom_range(0, 3)) spec_bytes.push_back(FLAG_SET[$urandom_range(0, 5)]);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
        repeat (n) spec_bytes.push_back(rand_digit());
        if ($urandom_range(0, 1) == 1)
        begin
            spec_bytes.push_back(".");
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
            repeat (n) spec_bytes.push_back(rand_digit());
        end
        if ($urandom_range(0, 2) != 0)
        begin
            spec_bytes.push_back(LEN_SET[$urandom_range(0, 7)]);
            if ($urandom_range(0, 2) == 0)
                spec_bytes.push_back($urandom_range(0, 1) ? "h" : "l");
        end
        if (kind < 22)
            spec_bytes.push_back(8'($urandom_range(0, 255)));
        else
            spec_bytes.push_back(CONV_SET[$urandom_range(0, 21)]);
    endtask

    // Result side: random stall bursts while idle_pct allows
    initial
    begin
        int stall_left;
        stall_left = 0;
        spec_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                spec_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                spec_bus.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                spec_bus.ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        spec_t got;
        spec_t want;
        bit    bad;
        if (rst_n && spec_bus.valid === 1'b1 && spec_bus.ready === 1'b1)
        begin
            got.flag_bits        = spec_bus.flag_bits;
            got.field_width      = spec_bus.field_width;
            got.precision_given  = spec_bus.precision_given;
            got.precision_value  = spec_bus.precision_value;
            got.length_first     = spec_bus.length_first;
            got.length_second    = spec_bus.length_second;
            got.conversion_found = spec_bus.conversion_found;
            got.conversion_char  = spec_bus.conversion_char;
            got.last_char_used   = spec_bus.last_char_used;
            if (pending_specs.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("tb: unexpected spec: %s", spec_text(got));
            end
            else
            begin
                want = pending_specs.pop_front();
                bad = (got.flag_bits !== want.flag_bits)
                    || (got.field_width !== want.field_width)
                    || (got.precision_given !== want.precision_given)
                    || (got.precision_value !== want.precision_value)
                    || (got.length_first !== want.length_first)
                    || (got.length_second !== want.length_second)
                    || (got.conversion_found !== want.conversion_found)
                    || (got.conversion_char !== want.conversion_char)
                    || (got.last_char_used !== want.last_char_used);
                if (bad)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("tb: spec mismatch\n  expected %s\n  actual   %s",
                            spec_text(want), spec_text(got));
                end
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int seg;
        int last_seg;
        char_bus.valid   = 1'b0;
        char_bus.char_in = 8'h00;
        clear_parse();
        dir_table = '{
            '{"%", 1'b0, SPEC_EMPTY}, '{"#", 1'b0, SPEC_EMPTY}, '{"0", 1'b0, SPEC_EMPTY},
            '{"-", 1'b0, SPEC_EMPTY}, '{" ", 1'b0, SPEC_EMPTY}, '{"+", 1'b0, SPEC_EMPTY},
            '{8'h27, 1'b0, SPEC_EMPTY},
            '{"9", 1'b0, SPEC_EMPTY}, '{"9", 1'b0, SPEC_EMPTY}, '{"9", 1'b0, SPEC_EMPTY},
            '{"9", 1'b0, SPEC_EMPTY}, '{"9", 1'b0, SPEC_EMPTY}, '{".", 1'b0, SPEC_EMPTY},
            '{"9", 1'b0, SPEC_EMPTY}, '{"9", 1'b0, SPEC_EMPTY}, '{"9", 1'b0, SPEC_EMPTY},
            '{"9", 1'b0, SPEC_EMPTY}, '{"9", 1'b0, SPEC_EMPTY},
            '{"q", 1'b0, SPEC_EMPTY}, '{"h", 1'b0, SPEC_EMPTY},
            '{"%", 1'b1, SPEC_SATURATED},
            '{8'hff, 1'b0, SPEC_EMPTY}, '{8'h00, 1'b1, SPEC_EMPTY},
            '{"%", 1'b0, SPEC_EMPTY}, '{"Z", 1'b0, SPEC_EMPTY}, '{"y", 1'b1, SPEC_Z_ONLY}
        };

        // Hold reset, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: all flags, saturation, q, any leading byte, NUL, Z, stray byte
        idle_pct = 30;
        foreach (dir_table[i])
            send_char(dir_table[i].ch, dir_table[i].typed, dir_table[i].want);

        // Random specs, idling level changed every hundred items, none at the end
        last_seg = -1;
        while (chars_sent < DIR_ROWS + RANDOM_ITEMS)
        begin
            seg = chars_sent / 100;
            if (chars_sent >= DIR_ROWS + RANDOM_ITEMS - QUIET_ITEMS)
                idle_pct = 0;
            else if (seg != last_seg)
            begin
                last_seg = seg;
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            build_spec();
            foreach (spec_bytes[i])
                send_char(spec_bytes[i], 1'b0, SPEC_EMPTY);
        end
        char_bus.valid <= 1'b0;

        // Drain, then wait for stray results
        while (pending_specs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
